>>> rtl/core/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion converter.
package rmq_pkg;
	localparam int FRAC_BITS = 14;
	localparam int EL_W      = 16;
	localparam int T_W       = EL_W + 2;
	localparam int RAD_W     = EL_W + 1;
	localparam int NUM_W     = EL_W + 1;
	localparam int ROOT_W    = 16;
	localparam int SQ_IN_W   = 2 * ROOT_W;
	localparam int SQ_REM_W  = ROOT_W + 2;
	localparam int SQ_ITER   = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_ITER;
	localparam int DVD_W     = NUM_W + FRAC_BITS;
	localparam int DVS_W     = ROOT_W + 1;
	localparam int Q_W       = 16;
	localparam int DV_ITER   = 2;
	localparam int DV_STAGES = Q_W / DV_ITER;
	localparam int ONE       = 1 << FRAC_BITS;

	localparam logic signed [EL_W-1:0] Q_MAX = 16'sh7fff;
	localparam logic signed [EL_W-1:0] Q_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	typedef logic signed [NUM_W-1:0] num_t;

	typedef struct packed {
		branch_t               branch;
		logic [RAD_W-1:0]      rad;
		num_t [2:0]            n;
	} sel_t;

	typedef struct packed {
		branch_t               branch;
		logic [ROOT_W-1:0]     root;
		num_t [2:0]            n;
	} root_t;

	typedef struct packed {
		logic [DVS_W-1:0]      rem;
		logic [Q_W-1:0]        quot;
		logic [Q_W-1:0]        low;
		logic                  ovf;
		logic                  neg;
	} dv_lane_t;

	typedef struct packed {
		branch_t               branch;
		logic [ROOT_W-1:0]     root;
		dv_lane_t [2:0]        ln;
	} dv_t;
endpackage

>>> rtl/core/rmq_ifs.sv
// Request channel interfaces: matrix in, quaternion out.
interface rmq_mat_if;
	import rmq_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [EL_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_quat_if;
	import rmq_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [EL_W-1:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0]             branch_used;
	modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_used,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_used,
		output ready);
endinterface

>>> rtl/core/rmq_select.sv
// Branch choice, radicand and numerators, one register stage.
module rmq_select (
	input  logic          clk,
	input  logic          arst_n,
	rmq_mat_if.sink       mat,
	output logic          out_valid,
	input  logic          out_ready,
	output rmq_pkg::sel_t out_data
);
	import rmq_pkg::*;

	logic signed [T_W-1:0] a00, a11, a22, t, rsel;
	num_t                  d12, d20, d01, s01, s02, s12;
	sel_t                  nxt;
	sel_t                  sel_s1;
	logic                  v_s1;

	always_comb begin
		a00 = T_W'(mat.m00);
		a11 = T_W'(mat.m11);
		a22 = T_W'(mat.m22);
		t   = a00 + a11 + a22 + T_W'(ONE);
		d12 = NUM_W'(mat.m12) - NUM_W'(mat.m21);
		d20 = NUM_W'(mat.m20) - NUM_W'(mat.m02);
		d01 = NUM_W'(mat.m01) - NUM_W'(mat.m10);
		s01 = NUM_W'(mat.m01) + NUM_W'(mat.m10);
		s02 = NUM_W'(mat.m02) + NUM_W'(mat.m20);
		s12 = NUM_W'(mat.m12) + NUM_W'(mat.m21);
		if (!t[T_W-1] && (t != '0)) begin
			nxt.branch = BR_TRACE;
			rsel       = t;
			nxt.n      = {d01, d20, d12};
		end else if ((a00 >= a11) && (a00 >= a22)) begin
			nxt.branch = BR_X;
			rsel       = T_W'(ONE) + a00 - a11 - a22;
			nxt.n      = {d12, s02, s01};
		end else if (a11 >= a22) begin
			nxt.branch = BR_Y;
			rsel       = T_W'(ONE) + a11 - a00 - a22;
			nxt.n      = {d20, s12, s01};
		end else begin
			nxt.branch = BR_Z;
			rsel       = T_W'(ONE) + a22 - a00 - a11;
			nxt.n      = {d01, s12, s02};
		end
		nxt.rad = rsel[T_W-1] ? '0 : rsel[RAD_W-1:0];
	end

	assign mat.ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (mat.ready) begin
			v_s1 <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mat.ready) begin
			sel_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = sel_s1;
endmodule

>>> rtl/core/rmq_isqrt.sv
// Pipelined digit-by-digit square root, two root bits per stage.
module rmq_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rmq_pkg::sel_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rmq_pkg::root_t out_data
);
	import rmq_pkg::*;

	typedef struct packed {
		branch_t               branch;
		num_t [2:0]            n;
		logic [SQ_REM_W-1:0]   rem;
		logic [ROOT_W-1:0]     root;
		logic [SQ_IN_W-1:0]    x;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a);
		sq_t                 b;
		logic [SQ_REM_W+1:0] cur, trial;
		b     = a;
		cur   = {a.rem, a.x[SQ_IN_W-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		if (cur >= trial) begin
			b.rem  = SQ_REM_W'(cur - trial);
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = cur[SQ_REM_W-1:0];
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		b.x = {a.x[SQ_IN_W-3:0], 2'b00};
		return b;
	endfunction

	sq_t  init;
	sq_t  sq_s [SQ_STAGES];
	logic vld  [SQ_STAGES];
	logic en   [SQ_STAGES];

	always_comb begin
		init.branch = in_data.branch;
		init.n      = in_data.n;
		init.rem    = '0;
		init.root   = '0;
		init.x      = {{(SQ_IN_W-RAD_W-FRAC_BITS){1'b0}}, in_data.rad, {FRAC_BITS{1'b0}}};
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		sq_t  src, res;
		logic vsrc, enx;
		if (k == 0) begin : g_first
			assign src  = init;
			assign vsrc = in_valid;
		end else begin : g_rest
			assign src  = sq_s[k-1];
			assign vsrc = vld[k-1];
		end
		if (k == SQ_STAGES - 1) begin : g_last
			assign enx = out_ready;
		end else begin : g_mid
			assign enx = en[k+1];
		end
		assign en[k] = !vld[k] || enx;

		always_comb begin
			res = src;
			for (int j = 0; j < SQ_ITER; j++) begin
				res = sq_step(res);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (en[k]) begin
				vld[k] <= vsrc;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				sq_s[k] <= res;
			end
		end
	end

	assign in_ready        = en[0];
	assign out_valid       = vld[SQ_STAGES-1];
	assign out_data.branch = sq_s[SQ_STAGES-1].branch;
	assign out_data.root   = sq_s[SQ_STAGES-1].root;
	assign out_data.n      = sq_s[SQ_STAGES-1].n;
endmodule

>>> rtl/core/rmq_div.sv
// Three-lane pipelined scaled divider n * ONE / 2r with rounding and overflow flag.
module rmq_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rmq_pkg::root_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rmq_pkg::dv_t   out_data
);
	import rmq_pkg::*;

	localparam int NST = DV_STAGES + 1;

	function automatic dv_t dv_prep(input root_t a);
		dv_t              b;
		logic [NUM_W-1:0] mag;
		logic [DVD_W-1:0] dvd;
		logic [DVS_W-1:0] dvs;
		b.branch = a.branch;
		b.root   = a.root;
		dvs      = {a.root, 1'b0};
		for (int i = 0; i < 3; i++) begin
			mag           = a.n[i][NUM_W-1] ? NUM_W'(-a.n[i]) : NUM_W'(a.n[i]);
			dvd           = {mag, {FRAC_BITS{1'b0}}} + DVD_W'(a.root);
			b.ln[i].ovf   = {1'b0, dvd} >= {dvs, {(Q_W-1){1'b0}}};
			b.ln[i].neg   = a.n[i][NUM_W-1];
			b.ln[i].rem   = DVS_W'(dvd[DVD_W-1:Q_W]);
			b.ln[i].low   = dvd[Q_W-1:0];
			b.ln[i].quot  = '0;
		end
		return b;
	endfunction

	function automatic dv_t dv_step(input dv_t a);
		dv_t              b;
		logic [DVS_W:0]   cur, dd;
		b  = a;
		dd = {1'b0, a.root, 1'b0};
		for (int i = 0; i < 3; i++) begin
			cur = {a.ln[i].rem, a.ln[i].low[Q_W-1]};
			if (cur >= dd) begin
				b.ln[i].rem  = DVS_W'(cur - dd);
				b.ln[i].quot = {a.ln[i].quot[Q_W-2:0], 1'b1};
			end else begin
				b.ln[i].rem  = cur[DVS_W-1:0];
				b.ln[i].quot = {a.ln[i].quot[Q_W-2:0], 1'b0};
			end
			b.ln[i].low = {a.ln[i].low[Q_W-2:0], 1'b0};
		end
		return b;
	endfunction

	dv_t  dv_s [NST];
	logic vld  [NST];
	logic en   [NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		dv_t  res;
		logic vsrc, enx;
		if (k == 0) begin : g_first
			assign res  = dv_prep(in_data);
			assign vsrc = in_valid;
		end else begin : g_rest
			always_comb begin
				res = dv_s[k-1];
				for (int j = 0; j < DV_ITER; j++) begin
					res = dv_step(res);
				end
			end
			assign vsrc = vld[k-1];
		end
		if (k == NST - 1) begin : g_last
			assign enx = out_ready;
		end else begin : g_mid
			assign enx = en[k+1];
		end
		assign en[k] = !vld[k] || enx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (en[k]) begin
				vld[k] <= vsrc;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				dv_s[k] <= res;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld[NST-1];
	assign out_data  = dv_s[NST-1];
endmodule

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Top level: 3x3 rotation matrix (Q2.14) to unit quaternion, Shepperd's method.
// Stages in order: select, square root, divider, output register.
// Throughput one matrix per cycle while the output is ready; every stage moves when it is empty or the next moves.
// A stalled output holds its request while bubbles upstream are still filled.
// Reset clears the valid bits of all stages; data registers are not reset.
module rotation_matrix_to_quaternion (
	input  logic      clk,
	input  logic      arst_n,
	rmq_mat_if.sink   mat,
	rmq_quat_if.source quat
);
	import rmq_pkg::*;

	logic  sel_valid, sel_ready, rt_valid, rt_ready, dv_valid, dv_ready;
	sel_t  sel_data;
	root_t rt_data;
	dv_t   dv_data;
	logic  vld_q;
	logic signed [EL_W-1:0] big, c1, c2, c3;

	rmq_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.mat      (mat),
		.out_valid(sel_valid),
		.out_ready(sel_ready),
		.out_data (sel_data)
	);

	rmq_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sel_valid),
		.in_ready (sel_ready),
		.in_data  (sel_data),
		.out_valid(rt_valid),
		.out_ready(rt_ready),
		.out_data (rt_data)
	);

	rmq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rt_valid),
		.in_ready (rt_ready),
		.in_data  (rt_data),
		.out_valid(dv_valid),
		.out_ready(dv_ready),
		.out_data (dv_data)
	);

	function automatic logic signed [EL_W-1:0] comp(input dv_lane_t l,
		input logic zero);
		logic signed [EL_W-1:0] v;
		if (zero) begin
			v = '0;
		end else if (l.ovf) begin
			v = l.neg ? Q_MIN : Q_MAX;
		end else begin
			v = l.neg ? EL_W'(-l.quot) : EL_W'(l.quot);
		end
		return v;
	endfunction

	always_comb begin
		big = (dv_data.root == '0) ? '0 :
			EL_W'(({1'b0, dv_data.root} + (ROOT_W+1)'(1)) >> 1);
		c1  = comp(dv_data.ln[0], dv_data.root == '0);
		c2  = comp(dv_data.ln[1], dv_data.root == '0);
		c3  = comp(dv_data.ln[2], dv_data.root == '0);
	end

	assign dv_ready   = !vld_q || quat.ready;
	assign quat.valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (dv_ready) begin
			vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready) begin
			quat.branch_used <= dv_data.branch;
			case (dv_data.branch)
				BR_TRACE: begin
					quat.quat_w <= big; quat.quat_x <= c1;
					quat.quat_y <= c2;  quat.quat_z <= c3;
				end
				BR_X: begin
					quat.quat_x <= big; quat.quat_y <= c1;
					quat.quat_z <= c2;  quat.quat_w <= c3;
				end
				BR_Y: begin
					quat.quat_y <= big; quat.quat_x <= c1;
					quat.quat_z <= c2;  quat.quat_w <= c3;
				end
				default: begin
					quat.quat_z <= big; quat.quat_x <= c1;
					quat.quat_y <= c2;  quat.quat_w <= c3;
				end
			endcase
		end
	end

	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(quat.valid && (quat.branch_used == BR_TRACE)) |-> !quat.quat_w[EL_W-1])
		else $error("root component w negative on trace path");
	a_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(quat.valid && (quat.branch_used == BR_X)) |-> !quat.quat_x[EL_W-1])
		else $error("root component x negative");
	a_y_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(quat.valid && (quat.branch_used == BR_Y)) |-> !quat.quat_y[EL_W-1])
		else $error("root component y negative");
	a_z_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(quat.valid && (quat.branch_used == BR_Z)) |-> !quat.quat_z[EL_W-1])
		else $error("root component z negative");
endmodule
